/* sv/linked_ring_queue_manager_top_defines.svh */
// Assertion macros for the linked ring queue manager.
// Included by the top level; expects clock and reset in scope at each use.
`ifndef LINKED_RING_QUEUE_MANAGER_TOP_DEFINES_SVH
`define LINKED_RING_QUEUE_MANAGER_TOP_DEFINES_SVH

// same-cycle implication
`define LRQM_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LRQM_ASSERT_FOLLOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/lrqm_pkg.sv */
// Package for the linked ring queue manager: field widths, command and status codes,
// micro-program step names, control word layout and the micro-program ROM.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lrqm_pkg;

   localparam int DEFAULT_ENTRIES = 32;
   localparam int DEFAULT_QUEUES  = 4;

   localparam int CMD_W    = 2;
   localparam int QSEL_W   = 2;
   localparam int ENTRY_W  = 5;
   localparam int STATUS_W = 2;
   localparam int RES_W    = 5;
   localparam int POS_W    = 5;
   localparam int UPC_W    = 4;

   localparam logic [POS_W-1:0] POS_MAX = '1;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT   = 2'd0,
      CMD_SHIFT    = 2'd1,
      CMD_REMOVE   = 2'd2,
      CMD_POSITION = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK           = 2'd0,
      ST_MISS         = 2'd1,
      ST_QUEUED       = 2'd2,
      ST_NOT_IN_QUEUE = 2'd3
   } status_type;

   typedef enum logic [UPC_W-1:0] {
      UP_FETCH     = 4'd0,
      UP_INS_RD    = 4'd1,
      UP_INS_LINK  = 4'd2,
      UP_INS_FIX   = 4'd3,
      UP_SHF_CHK   = 4'd4,
      UP_REM_RD    = 4'd5,
      UP_REM_UPD   = 4'd6,
      UP_POS_RD    = 4'd7,
      UP_POS_CHK   = 4'd8,
      UP_WALK_TEST = 4'd9,
      UP_WALK_LOAD = 4'd10,
      UP_DONE      = 4'd11,
      UP_CLEAR     = 4'd12
   } upc_type;

   typedef enum logic [1:0] {
      ADDR_ENTRY = 2'd0,
      ADDR_HEAD  = 2'd1,
      ADDR_CUR   = 2'd2
   } addr_sel_type;

   typedef enum logic [3:0] {
      ACT_NONE      = 4'd0,
      ACT_FETCH     = 4'd1,
      ACT_CLEAR     = 4'd2,
      ACT_INS_LINK  = 4'd3,
      ACT_INS_FIX   = 4'd4,
      ACT_SHF_CHK   = 4'd5,
      ACT_UNLINK    = 4'd6,
      ACT_WALK_INIT = 4'd7,
      ACT_POS_CHK   = 4'd8,
      ACT_WALK_TEST = 4'd9,
      ACT_WALK_LOAD = 4'd10,
      ACT_RESPOND   = 4'd11
   } act_type;

   typedef enum logic [2:0] {
      BR_NEXT  = 3'd0,
      BR_GOTO  = 3'd1,
      BR_IF    = 3'd2,
      BR_WAIT  = 3'd3,
      BR_FETCH = 3'd4
   } br_type;

   typedef enum logic [2:0] {
      COND_NONE      = 3'd0,
      COND_INS_END   = 3'd1,
      COND_EMPTY     = 3'd2,
      COND_POS_FAIL  = 3'd3,
      COND_WALK_END  = 3'd4,
      COND_CLEAR_END = 3'd5,
      COND_OUT_FREE  = 3'd6
   } cond_type;

   typedef struct packed {
      addr_sel_type addr_sel;
      logic         rd;
      act_type      act;
      br_type       br;
      cond_type     cond;
      upc_type      target;
   } ucode_type;

   function automatic ucode_type ucode_rom(input upc_type a);
      ucode_type w;
      unique case (a)
         UP_FETCH:     w = '{ADDR_ENTRY, 1'b0, ACT_FETCH,     BR_FETCH, COND_NONE,      UP_FETCH};
         UP_INS_RD:    w = '{ADDR_HEAD,  1'b1, ACT_NONE,      BR_NEXT,  COND_NONE,      UP_FETCH};
         UP_INS_LINK:  w = '{ADDR_HEAD,  1'b0, ACT_INS_LINK,  BR_IF,    COND_INS_END,   UP_DONE};
         UP_INS_FIX:   w = '{ADDR_HEAD,  1'b0, ACT_INS_FIX,   BR_GOTO,  COND_NONE,      UP_DONE};
         UP_SHF_CHK:   w = '{ADDR_ENTRY, 1'b0, ACT_SHF_CHK,   BR_IF,    COND_EMPTY,     UP_DONE};
         UP_REM_RD:    w = '{ADDR_ENTRY, 1'b1, ACT_NONE,      BR_NEXT,  COND_NONE,      UP_FETCH};
         UP_REM_UPD:   w = '{ADDR_ENTRY, 1'b0, ACT_UNLINK,    BR_GOTO,  COND_NONE,      UP_DONE};
         UP_POS_RD:    w = '{ADDR_ENTRY, 1'b1, ACT_WALK_INIT, BR_NEXT,  COND_NONE,      UP_FETCH};
         UP_POS_CHK:   w = '{ADDR_ENTRY, 1'b0, ACT_POS_CHK,   BR_IF,    COND_POS_FAIL,  UP_DONE};
         UP_WALK_TEST: w = '{ADDR_CUR,   1'b1, ACT_WALK_TEST, BR_IF,    COND_WALK_END,  UP_DONE};
         UP_WALK_LOAD: w = '{ADDR_CUR,   1'b0, ACT_WALK_LOAD, BR_GOTO,  COND_NONE,      UP_WALK_TEST};
         UP_DONE:      w = '{ADDR_ENTRY, 1'b0, ACT_RESPOND,   BR_WAIT,  COND_OUT_FREE,  UP_FETCH};
         UP_CLEAR:     w = '{ADDR_ENTRY, 1'b0, ACT_CLEAR,     BR_WAIT,  COND_CLEAR_END, UP_FETCH};
         default:      w = '{ADDR_ENTRY, 1'b0, ACT_NONE,      BR_GOTO,  COND_NONE,      UP_FETCH};
      endcase
      return w;
   endfunction

   function automatic upc_type dispatch(input cmd_type c);
      upc_type t;
      unique case (c)
         CMD_INSERT:   t = UP_INS_RD;
         CMD_SHIFT:    t = UP_SHF_CHK;
         CMD_REMOVE:   t = UP_REM_RD;
         CMD_POSITION: t = UP_POS_RD;
         default:      t = UP_DONE;
      endcase
      return t;
   endfunction

endpackage

`default_nettype wire

/* sv/lrqm_req_if.sv */
// Command channel of the linked ring queue manager: valid/ready plus the item fields.
// Depends on lrqm_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface lrqm_req_if;
   import lrqm_pkg::*;

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [QSEL_W-1:0] queue_sel;
   logic [ENTRY_W-1:0] entry;

   modport source (output valid, cmd, queue_sel, entry, input ready);
   modport sink (input valid, cmd, queue_sel, entry, output ready);
endinterface

`default_nettype wire

/* sv/lrqm_rsp_if.sv */
// Result channel of the linked ring queue manager: valid/ready plus the item fields.
// Depends on lrqm_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface lrqm_rsp_if;
   import lrqm_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [RES_W-1:0]    result_entry;
   logic [POS_W-1:0]    position;

   modport source (output valid, status, result_entry, position, input ready);
   modport sink (input valid, status, result_entry, position, output ready);
endinterface

`default_nettype wire

/* sv/linked_ring_queue_manager_top.sv */
// Linked ring queue manager top level: micro-programmed sequencer over link and
// membership RAMs. Depends on lrqm_pkg, lrqm_req_if, lrqm_rsp_if, lrqm_ram and the defines header.
//
// Usage: commands arrive on req_port (insert at tail, shift head, remove entry, position
// query), each naming a queue and an entry. Every command yields one item on rsp_port
// with a status, the shifted entry and the position. One command is in work at a time;
// req_port.ready is high only while the sequencer waits at its fetch step.
// Steps after accept: remove reads the entry's links, then unlinks it; insert reads the head's
// links, links the entry and, unless it was queued already or the queue was empty, fixes the
// neighbours; shift checks for an empty queue, then removes the head; position reads, checks
// membership, then walks from the head through the single read port of the next-link RAM.
// All end at the final step, which loads the response; a bad queue or entry goes straight there.
// Reset: synchronous. After reset a clearing pass writes all ENTRIES link and membership
// words, one a cycle, with req_port.ready low; queue 0 then holds every entry in index order.
// Stall: a response sits in an output register; a new command is accepted while it
// waits, but the sequencer holds at its final step until the register is free.
`timescale 1ns / 1ps
`default_nettype none
`include "linked_ring_queue_manager_top_defines.svh"

module linked_ring_queue_manager_top #(
   parameter int ENTRIES = lrqm_pkg::DEFAULT_ENTRIES,
   parameter int QUEUES  = lrqm_pkg::DEFAULT_QUEUES
) (
   input  logic       clock,
   input  logic       reset,
   lrqm_req_if.sink   req_port,
   lrqm_rsp_if.source rsp_port
);
   import lrqm_pkg::*;

   localparam int EW = $clog2(ENTRIES);
   localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
   localparam int MW = QW + 1;
   localparam logic [EW-1:0] LAST_IDX = EW'(ENTRIES - 1);

   upc_type          upc_ff, upc_in;
   cmd_type          cmd_ff, cmd_in;
   logic [QW-1:0]    q_ff, q_in;
   logic [EW-1:0]    e_ff, e_in;
   logic [EW-1:0]    cur_ff, cur_in;
   logic [EW-1:0]    cnt_ff, cnt_in;
   logic [EW-1:0]    clr_ff, clr_in;
   status_type       status_ff, status_in;
   logic [RES_W-1:0] res_ff, res_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [EW-1:0]    head_ff [QUEUES];
   logic [EW-1:0]    head_in [QUEUES];
   logic [QUEUES-1:0] nonempty_ff, nonempty_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [RES_W-1:0] rsp_res_ff, rsp_res_in;
   logic [POS_W-1:0] rsp_pos_ff, rsp_pos_in;

   ucode_type     uc;
   logic          req_fire;
   logic          req_bad;
   logic          out_free;
   logic          cond_val;
   logic [EW-1:0] head_q;
   logic          ne_q;
   logic          entry_ok;
   logic [EW-1:0] link_addr;
   logic [EW-1:0] clear_next;
   logic [EW-1:0] clear_prev;
   logic [POS_W-1:0] pos_sat;

   logic          next_we, prev_we, meta_we;
   logic [EW-1:0] next_waddr, prev_waddr, meta_waddr;
   logic [EW-1:0] next_wdata, prev_wdata;
   logic [MW-1:0] meta_wdata;
   logic [EW-1:0] next_rdata, prev_rdata;
   logic [MW-1:0] meta_rdata;
   logic          meta_queued;
   logic [QW-1:0] meta_owner;

   lrqm_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_next_ram (
      .clock   (clock),
      .wr_en   (next_we),
      .wr_addr (next_waddr),
      .wr_data (next_wdata),
      .rd_en   (uc.rd),
      .rd_addr (link_addr),
      .rd_data (next_rdata)
   );

   lrqm_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_we),
      .wr_addr (prev_waddr),
      .wr_data (prev_wdata),
      .rd_en   (uc.rd),
      .rd_addr (link_addr),
      .rd_data (prev_rdata)
   );

   lrqm_ram #(.WIDTH(MW), .DEPTH(ENTRIES)) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_we),
      .wr_addr (meta_waddr),
      .wr_data (meta_wdata),
      .rd_en   (uc.rd),
      .rd_addr (e_ff),
      .rd_data (meta_rdata)
   );

   assign uc          = ucode_rom(upc_ff);
   assign meta_queued = meta_rdata[QW];
   assign meta_owner  = meta_rdata[QW-1:0];
   assign head_q      = head_ff[q_ff];
   assign ne_q        = nonempty_ff[q_ff];
   assign entry_ok    = ne_q && meta_queued && (meta_owner == q_ff);
   assign req_fire    = req_port.valid && req_port.ready;
   assign out_free    = !rsp_valid_ff || rsp_port.ready;
   assign req_bad     = (int'(req_port.queue_sel) >= QUEUES)
                     || ((cmd_type'(req_port.cmd) != CMD_SHIFT)
                         && (int'(req_port.entry) >= ENTRIES));
   assign clear_next  = (clr_ff == LAST_IDX) ? '0 : clr_ff + 1'b1;
   assign clear_prev  = (clr_ff == '0) ? LAST_IDX : clr_ff - 1'b1;
   assign pos_sat     = (32'(cnt_ff) > 32'(POS_MAX)) ? POS_MAX : POS_W'(cnt_ff);

   assign req_port.ready        = (upc_ff == UP_FETCH);
   assign rsp_port.valid        = rsp_valid_ff;
   assign rsp_port.status       = rsp_status_ff;
   assign rsp_port.result_entry = rsp_res_ff;
   assign rsp_port.position     = rsp_pos_ff;

   always_comb begin
      unique case (uc.addr_sel)
         ADDR_ENTRY: link_addr = e_ff;
         ADDR_HEAD:  link_addr = head_q;
         ADDR_CUR:   link_addr = cur_ff;
         default:    link_addr = e_ff;
      endcase
   end

   always_comb begin
      unique case (uc.cond)
         COND_NONE:      cond_val = 1'b0;
         COND_INS_END:   cond_val = meta_queued || !ne_q;
         COND_EMPTY:     cond_val = !ne_q;
         COND_POS_FAIL:  cond_val = !entry_ok;
         COND_WALK_END:  cond_val = (cur_ff == e_ff) || (cnt_ff == LAST_IDX);
         COND_CLEAR_END: cond_val = (clr_ff == LAST_IDX);
         COND_OUT_FREE:  cond_val = out_free;
         default:        cond_val = 1'b0;
      endcase
   end

   always_comb begin
      unique case (uc.br)
         BR_NEXT:  upc_in = upc_type'(upc_ff + 4'd1);
         BR_GOTO:  upc_in = uc.target;
         BR_IF:    upc_in = cond_val ? uc.target : upc_type'(upc_ff + 4'd1);
         BR_WAIT:  upc_in = cond_val ? uc.target : upc_ff;
         BR_FETCH: begin
            if (!req_fire) begin
               upc_in = upc_ff;
            end else if (req_bad) begin
               upc_in = UP_DONE;
            end else begin
               upc_in = dispatch(cmd_type'(req_port.cmd));
            end
         end
         default:  upc_in = UP_FETCH;
      endcase
   end

   always_comb begin
      cmd_in        = cmd_ff;
      q_in          = q_ff;
      e_in          = e_ff;
      cur_in        = cur_ff;
      cnt_in        = cnt_ff;
      clr_in        = clr_ff;
      status_in     = status_ff;
      res_in        = res_ff;
      pos_in        = pos_ff;
      head_in       = head_ff;
      nonempty_in   = nonempty_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_port.ready;
      rsp_status_in = rsp_status_ff;
      rsp_res_in    = rsp_res_ff;
      rsp_pos_in    = rsp_pos_ff;
      next_we       = 1'b0;
      prev_we       = 1'b0;
      meta_we       = 1'b0;
      next_waddr    = e_ff;
      prev_waddr    = e_ff;
      meta_waddr    = e_ff;
      next_wdata    = e_ff;
      prev_wdata    = e_ff;
      meta_wdata    = '0;

      unique case (uc.act)
         ACT_NONE: begin
         end
         ACT_FETCH: begin
            if (req_fire) begin
               cmd_in    = cmd_type'(req_port.cmd);
               q_in      = QW'(req_port.queue_sel);
               e_in      = EW'(req_port.entry);
               status_in = req_bad ? ST_MISS : ST_OK;
               res_in    = '0;
               pos_in    = '0;
            end
         end
         ACT_CLEAR: begin
            next_we    = 1'b1;
            prev_we    = 1'b1;
            meta_we    = 1'b1;
            next_waddr = clr_ff;
            prev_waddr = clr_ff;
            meta_waddr = clr_ff;
            next_wdata = clear_next;
            prev_wdata = clear_prev;
            meta_wdata = {1'b1, QW'(0)};
            clr_in     = clr_ff + 1'b1;
         end
         ACT_INS_LINK: begin
            if (meta_queued) begin
               status_in = ST_QUEUED;
            end else begin
               next_we    = 1'b1;
               prev_we    = 1'b1;
               meta_we    = 1'b1;
               next_wdata = ne_q ? head_q : e_ff;
               prev_wdata = ne_q ? prev_rdata : e_ff;
               meta_wdata = {1'b1, q_ff};
               if (!ne_q) begin
                  head_in[q_ff]     = e_ff;
                  nonempty_in[q_ff] = 1'b1;
               end
            end
         end
         ACT_INS_FIX: begin
            next_we    = 1'b1;
            prev_we    = 1'b1;
            next_waddr = prev_rdata;
            prev_waddr = head_q;
            next_wdata = e_ff;
            prev_wdata = e_ff;
         end
         ACT_SHF_CHK: begin
            if (!ne_q) begin
               status_in = ST_MISS;
            end else begin
               e_in = head_q;
            end
         end
         ACT_UNLINK: begin
            if (!entry_ok) begin
               status_in = ST_NOT_IN_QUEUE;
            end else begin
               next_we    = 1'b1;
               prev_we    = 1'b1;
               meta_we    = 1'b1;
               next_waddr = prev_rdata;
               prev_waddr = next_rdata;
               next_wdata = next_rdata;
               prev_wdata = prev_rdata;
               meta_wdata = '0;
               if (head_q == e_ff) begin
                  if (next_rdata == e_ff) begin
                     head_in[q_ff]     = '0;
                     nonempty_in[q_ff] = 1'b0;
                  end else begin
                     head_in[q_ff] = next_rdata;
                  end
               end
               if (cmd_ff == CMD_SHIFT) begin
                  res_in = RES_W'(e_ff);
               end
            end
         end
         ACT_WALK_INIT: begin
            cur_in = head_q;
            cnt_in = '0;
         end
         ACT_POS_CHK: begin
            if (!entry_ok) begin
               status_in = ST_MISS;
            end
         end
         ACT_WALK_TEST: begin
            if (cur_ff == e_ff) begin
               pos_in = pos_sat;
            end else if (cnt_ff == LAST_IDX) begin
               status_in = ST_MISS;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ACT_WALK_LOAD: begin
            cur_in = next_rdata;
         end
         ACT_RESPOND: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_res_in    = res_ff;
               rsp_pos_in    = pos_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= UP_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < QUEUES; i++) begin
            head_ff[i]     <= '0;
            nonempty_ff[i] <= (i == 0);
         end
      end else begin
         upc_ff       <= upc_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         nonempty_ff  <= nonempty_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      q_ff          <= q_in;
      e_ff          <= e_in;
      cur_ff        <= cur_in;
      cnt_ff        <= cnt_in;
      status_ff     <= status_in;
      res_ff        <= res_in;
      pos_ff        <= pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_res_ff    <= rsp_res_in;
      rsp_pos_ff    <= rsp_pos_in;
   end

   for (genvar gq = 0; gq < QUEUES; gq++) begin : g_head_chk
      `LRQM_ASSERT_IMPLY(a_empty_head_zero, !nonempty_ff[gq], head_ff[gq] == '0, "empty queue has nonzero head")
   end

   `LRQM_ASSERT_FOLLOW(a_done_loads_rsp, (upc_ff == UP_DONE) && out_free, rsp_valid_ff && (upc_ff == UP_FETCH), "final step did not hand over the item")

   `LRQM_ASSERT_IMPLY(a_fail_fields_zero, rsp_valid_ff && (rsp_status_ff != ST_OK), (rsp_res_ff == '0) && (rsp_pos_ff == '0), "failed command carries data")

endmodule

`default_nettype wire

/* sv/lrqm_ram.sv */
// Generic single-write, single-read RAM with registered, enabled read data.
// Depends on lrqm_pkg for parameter defaults only.
`timescale 1ns / 1ps
`default_nettype none

module lrqm_ram #(
   parameter int WIDTH = lrqm_pkg::ENTRY_W,
   parameter int DEPTH = lrqm_pkg::DEFAULT_ENTRIES
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

`default_nettype wire

/* verif/lrqm_reply_checker.sv */
// Reply checker for the linked ring queue manager: keeps its own linked pool,
// predicts each reply from the accepted commands and compares the replies.
// Depends on lrqm_pkg, lrqm_req_if and lrqm_rsp_if.
`timescale 1ns / 1ps

module lrqm_reply_checker (
   input  logic   clock,
   input  logic   reset,
   lrqm_req_if    req_bus,
   lrqm_rsp_if    rsp_bus,
   output int     fail_count,
   output int     replies_pending
);
   import lrqm_pkg::*;

   localparam int POOL = DEFAULT_ENTRIES;
   localparam int RINGS = DEFAULT_QUEUES;

   typedef struct packed {
      status_type         status;
      logic [RES_W-1:0]   taken;
      logic [POS_W-1:0]   spot;
   } reply_type;

   logic [ENTRY_W-1:0] link_next [POOL];
   logic [ENTRY_W-1:0] link_prev [POOL];
   logic               is_queued [POOL];
   logic [QSEL_W-1:0]  owner_q   [POOL];
   logic [ENTRY_W-1:0] q_head    [RINGS];
   logic               q_busy    [RINGS];

   reply_type replies_due[$];
   int        n_fail = 0;

   function automatic void restore_pool();
      for (int i = 0; i < POOL; i++) begin
         link_next[i] = ENTRY_W'((i + 1) % POOL);
         link_prev[i] = ENTRY_W'((i + POOL - 1) % POOL);
         is_queued[i] = 1'b1;
         owner_q[i]   = '0;
      end
      for (int k = 0; k < RINGS; k++) begin
         q_head[k] = '0;
         q_busy[k] = (k == 0);
      end
   endfunction

   // close the ring around e and leave e pointing at itself
   function automatic void detach(logic [ENTRY_W-1:0] e);
      logic [ENTRY_W-1:0] n, p;
      n = link_next[e];
      p = link_prev[e];
      link_next[p] = n;
      link_prev[n] = p;
      link_next[e] = e;
      link_prev[e] = e;
      is_queued[e] = 1'b0;
      owner_q[e]   = '0;
   endfunction

   function automatic reply_type apply_command(cmd_type op, logic [QSEL_W-1:0] q,
                                               logic [ENTRY_W-1:0] e);
      reply_type          r;
      logic [ENTRY_W-1:0] h, t, cur;
      int                 steps;
      r = '{ST_OK, '0, '0};
      case (op)
         CMD_SHIFT: begin
            if (!q_busy[q]) begin
               r.status = ST_MISS;
            end else begin
               h = q_head[q];
               if (link_next[h] == h) begin
                  q_busy[q] = 1'b0;
                  q_head[q] = '0;
               end else begin
                  q_head[q] = link_next[h];
               end
               detach(h);
               r.taken = h;
            end
         end
         CMD_INSERT: begin
            if (is_queued[e]) begin
               r.status = ST_QUEUED;
            end else begin
               if (!q_busy[q]) begin
                  link_next[e] = e;
                  link_prev[e] = e;
                  q_head[q] = e;
                  q_busy[q] = 1'b1;
               end else begin
                  h = q_head[q];
                  t = link_prev[h];
                  link_prev[e] = t;
                  link_next[e] = h;
                  link_next[t] = e;
                  link_prev[h] = e;
               end
               is_queued[e] = 1'b1;
               owner_q[e]   = q;
            end
         end
         CMD_REMOVE: begin
            if (!q_busy[q] || !is_queued[e] || owner_q[e] != q) begin
               r.status = ST_NOT_IN_QUEUE;
            end else begin
               if (q_head[q] == e) begin
                  if (link_next[e] == e) begin
                     q_busy[q] = 1'b0;
                     q_head[q] = '0;
                  end else begin
                     q_head[q] = link_next[e];
                  end
               end
               detach(e);
            end
         end
         default: begin
            if (!q_busy[q] || !is_queued[e] || owner_q[e] != q) begin
               r.status = ST_MISS;
            end else begin
               cur = q_head[q];
               steps = 0;
               while (steps < POOL && cur != e) begin
                  cur = link_next[cur];
                  steps++;
               end
               if (steps < POOL) r.spot = (steps > 31) ? POS_MAX : POS_W'(steps);
               else r.status = ST_MISS;
            end
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         restore_pool();
         replies_due.delete();
      end else begin
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (replies_due.size() == 0) begin
               $error("reply with no command outstanding: status %0d entry %0d position %0d",
                      rsp_bus.status, rsp_bus.result_entry, rsp_bus.position);
               n_fail++;
            end else begin
               want = replies_due.pop_front();
               if (rsp_bus.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_bus.status);
                  n_fail++;
               end
               if (rsp_bus.result_entry !== want.taken) begin
                  $error("result_entry: expected %0d, actual %0d",
                         want.taken, rsp_bus.result_entry);
                  n_fail++;
               end
               if (rsp_bus.position !== want.spot) begin
                  $error("position: expected %0d, actual %0d", want.spot, rsp_bus.position);
                  n_fail++;
               end
            end
         end
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1)
            replies_due.push_back(apply_command(cmd_type'(req_bus.cmd), req_bus.queue_sel,
                                                req_bus.entry));
      end
      fail_count      <= n_fail;
      replies_pending <= replies_due.size();
   end

endmodule

/* verif/tb_top.sv */
// Testbench top for the linked ring queue manager: drives directed and random
// queue commands in bursts, stalls the reply side and gives the verdict.
// Depends on lrqm_pkg, both channel interfaces, the block and lrqm_reply_checker.
`timescale 1ns / 1ps

module tb_top;
   import lrqm_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS   = 750;

   logic clock = 1'b0;
   logic reset;
   int   fail_count;
   int   replies_pending;
   int   idle_cycles = 0;

   // stimulus-side view of queue contents, used only to aim commands
   int members [DEFAULT_QUEUES][$];
   int home    [DEFAULT_ENTRIES];
   int burst_left = 0;

   lrqm_req_if req_bus ();
   lrqm_rsp_if rsp_bus ();

   linked_ring_queue_manager_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   lrqm_reply_checker reply_checker (
      .clock           (clock),
      .reset           (reset),
      .req_bus         (req_bus),
      .rsp_bus         (rsp_bus),
      .fail_count      (fail_count),
      .replies_pending (replies_pending)
   );

   always #5 clock = ~clock;

   function automatic void track(cmd_type c, int q, int e);
      case (c)
         CMD_INSERT: begin
            if (home[e] < 0) begin
               members[q].push_back(e);
               home[e] = q;
            end
         end
         CMD_SHIFT: begin
            if (members[q].size() > 0) begin
               home[members[q][0]] = -1;
               void'(members[q].pop_front());
            end
         end
         CMD_REMOVE: begin
            if (home[e] == q) begin
               for (int i = 0; i < members[q].size(); i++) begin
                  if (members[q][i] == e) begin
                     members[q].delete(i);
                     break;
                  end
               end
               home[e] = -1;
            end
         end
         default: ;
      endcase
   endfunction

   function automatic logic [ENTRY_W-1:0] pick_entry(cmd_type c, int q);
      int spare[$];
      if ($urandom_range(0, 3) != 0) begin
         if (c == CMD_INSERT) begin
            for (int i = 0; i < DEFAULT_ENTRIES; i++)
               if (home[i] < 0) spare.push_back(i);
            if (spare.size() > 0) return ENTRY_W'(spare[$urandom_range(0, spare.size() - 1)]);
         end else if (members[q].size() > 0) begin
            return ENTRY_W'(members[q][$urandom_range(0, members[q].size() - 1)]);
         end
      end
      return ENTRY_W'($urandom_range(0, DEFAULT_ENTRIES - 1));
   endfunction

   task automatic send_item(cmd_type c, int q, int e);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_bus.valid     <= 1'b1;
      req_bus.cmd       <= c;
      req_bus.queue_sel <= QSEL_W'(q);
      req_bus.entry     <= ENTRY_W'(e);
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      track(c, q, e);
   endtask

   // reply side: random stall patterns with one long hold-off
   initial begin
      int rounds;
      int span;
      int mode;
      rounds = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(10, 60);
         if (rounds == 12) begin
            rsp_bus.ready <= 1'b0;
            repeat (300) @(posedge clock);
         end else begin
            repeat (span) begin
               case (mode)
                  0: rsp_bus.ready <= 1'b1;
                  1: rsp_bus.ready <= 1'($urandom_range(0, 1));
                  2: rsp_bus.ready <= ($urandom_range(0, 4) != 0);
                  default: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               endcase
               @(posedge clock);
            end
         end
         rounds++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("tb_top failed");
            $finish;
         end
      end
   end

   initial begin
      cmd_type c;
      int      q;
      int      pick;
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.cmd       <= CMD_INSERT;
      req_bus.queue_sel <= '0;
      req_bus.entry     <= '0;
      for (int i = 0; i < DEFAULT_ENTRIES; i++) begin
         members[0].push_back(i);
         home[i] = 0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_item(CMD_POSITION, 0, 31);
      send_item(CMD_POSITION, 0, 0);
      send_item(CMD_SHIFT,    1, 9);
      send_item(CMD_POSITION, 2, 5);
      send_item(CMD_REMOVE,   3, 7);
      send_item(CMD_INSERT,   1, 4);
      send_item(CMD_REMOVE,   1, 4);
      send_item(CMD_SHIFT,    0, 0);
      send_item(CMD_INSERT,   3, 0);
      send_item(CMD_REMOVE,   0, 31);
      send_item(CMD_INSERT,   3, 31);
      send_item(CMD_POSITION, 3, 31);
      send_item(CMD_REMOVE,   0, 17);
      send_item(CMD_INSERT,   2, 17);
      send_item(CMD_SHIFT,    3, 0);
      send_item(CMD_SHIFT,    3, 0);
      send_item(CMD_SHIFT,    3, 0);
      send_item(CMD_INSERT,   3, 31);
      send_item(CMD_REMOVE,   3, 31);
      send_item(CMD_REMOVE,   0, 1);
      send_item(CMD_POSITION, 0, 2);
      send_item(CMD_INSERT,   1, 1);
      send_item(CMD_INSERT,   1, 0);
      send_item(CMD_INSERT,   1, 31);
      send_item(CMD_POSITION, 1, 31);

      repeat (RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 30)      c = CMD_INSERT;
         else if (pick < 50) c = CMD_SHIFT;
         else if (pick < 75) c = CMD_REMOVE;
         else                c = CMD_POSITION;
         q = $urandom_range(0, DEFAULT_QUEUES - 1);
         send_item(c, q, pick_entry(c, q));
      end
      req_bus.valid <= 1'b0;

      @(posedge clock);
      wait (replies_pending == 0);
      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
